/* hw/rtl/ps2m_pkg.sv */
// Shared constants and types for the PS/2 mouse packet decoder.
package ps2m_pkg;

  // Default pointer coordinate width
  localparam int unsigned COORD_BITS_DEFAULT = 12;

  // Configuration port geometry
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 13;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

  // Register reset values
  localparam logic [CFG_DATA_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
  localparam logic [CFG_DATA_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;

  // Flags byte bit positions
  localparam int unsigned FLAG_SYNC_BIT  = 3;
  localparam int unsigned FLAG_XSIGN_BIT = 4;
  localparam int unsigned FLAG_YSIGN_BIT = 5;
  localparam int unsigned FLAG_XOVF_BIT  = 6;
  localparam int unsigned FLAG_YOVF_BIT  = 7;

  // Position within a three-byte packet
  typedef enum logic [1:0] {
    IDX_FLAGS = 2'd0,
    IDX_DX    = 2'd1,
    IDX_DY    = 2'd2
  } byte_idx_t;

endpackage

/* hw/rtl/ps2m_poll_if.sv */
// Valid/ready channel carrying one controller poll per beat.
interface ps2m_poll_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic       data_ready;
  logic       from_aux;
  logic [7:0] data_byte;

  modport source (output valid, command, data_ready, from_aux, data_byte, input ready);
  modport sink   (input valid, command, data_ready, from_aux, data_byte, output ready);
endinterface

/* hw/rtl/ps2m_report_if.sv */
// Valid/ready channel carrying one pointer report per beat.
interface ps2m_report_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  packet_done;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic                  button_left;
  logic                  button_right;
  logic                  button_middle;

  modport source (output valid, packet_done, pos_x, pos_y, button_left, button_right,
                  button_middle, input ready);
  modport sink   (input valid, packet_done, pos_x, pos_y, button_left, button_right,
                  button_middle, output ready);
endinterface

/* hw/rtl/ps2_mouse_packet_decoder.sv */
// PS/2 mouse packet decoder: top level with packet assembly, pointer update and report buffer.
//
// One poll beat is accepted per clock while the skid register is empty and yields exactly one
// report beat. Packet state and pointer position update in the accept cycle through a single
// add-and-clamp per axis, and the report is registered. A one-entry skid register behind the
// output register lets the poll side keep going for one beat while the report side stalls, so
// sustained throughput is one beat per cycle whenever reports are taken. The user must write
// the screen size registers through the cfg port only while no beat is in flight; the block
// does not enforce this. A size of 0 acts as 1, one above 2**COORD_BITS as 2**COORD_BITS.
module ps2_mouse_packet_decoder
  import ps2m_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  ps2m_poll_if.sink                 poll,
  ps2m_report_if.source             report
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned EXT = (CB + 1 > CFG_DATA_BITS) ? CB + 1 : CFG_DATA_BITS;

  // Effective screen size: clamp register value to [1, 2**CB]
  function automatic logic [CB:0] eff_size(input logic [CFG_DATA_BITS-1:0] r);
    logic [EXT-1:0] rx;
    logic [EXT-1:0] lim;
    logic [CB:0]    s;
    rx  = EXT'(r);
    lim = EXT'(1) << CB;
    if (rx == '0) begin
      s = (CB+1)'(1);
    end else if (rx > lim) begin
      s = lim[CB:0];
    end else begin
      s = rx[CB:0];
    end
    return s;
  endfunction

  // Clamp a signed candidate coordinate to [0, size-1]
  function automatic logic [CB-1:0] clamp_coord(input logic signed [CB+1:0] v,
                                                input logic [CB:0] size);
    logic [CB:0]   sm1;
    logic [CB-1:0] c;
    sm1 = size - (CB+1)'(1);
    if (v[CB+1]) begin
      c = '0;
    end else if (v[CB:0] >= size) begin
      c = sm1[CB-1:0];
    end else begin
      c = v[CB-1:0];
    end
    return c;
  endfunction

  localparam logic [CB:0]   RST_EFF_W = eff_size(SCREEN_WIDTH_RESET);
  localparam logic [CB:0]   RST_EFF_H = eff_size(SCREEN_HEIGHT_RESET);
  localparam logic [CB-1:0] RST_POS_X = RST_EFF_W[CB:1];
  localparam logic [CB-1:0] RST_POS_Y = RST_EFF_H[CB:1];

  // Configuration registers
  logic [CFG_DATA_BITS-1:0] screen_width;
  logic [CFG_DATA_BITS-1:0] screen_height;

  // Decoder state
  byte_idx_t     byte_index, byte_index_next;
  logic [7:0]    flags_byte, flags_byte_next;
  logic [7:0]    dx_byte, dx_byte_next;
  logic [CB-1:0] position_x, position_x_next;
  logic [CB-1:0] position_y, position_y_next;
  logic [2:0]    buttons, buttons_next;
  logic          done;

  // Output register and skid register
  logic          main_valid;
  logic          main_done;
  logic [CB-1:0] main_x, main_y;
  logic [2:0]    main_btn;
  logic          skid_valid;
  logic          skid_done;
  logic [CB-1:0] skid_x, skid_y;
  logic [2:0]    skid_btn;

  logic              poll_acc;
  logic              report_acc;
  logic [CB:0]       eff_w, eff_h;
  logic signed [CB+1:0] cand_x, cand_y;

  assign poll.ready = !skid_valid;
  assign poll_acc   = poll.valid && poll.ready;
  assign report_acc = main_valid && report.ready;

  assign eff_w = eff_size(screen_width);
  assign eff_h = eff_size(screen_height);

  // Candidate coordinates: x + dx, y - dy with 9-bit signed deltas
  assign cand_x = $signed({2'b00, position_x})
                + $signed({{(CB-6){flags_byte[FLAG_XSIGN_BIT]}}, dx_byte});
  assign cand_y = $signed({2'b00, position_y})
                - $signed({{(CB-6){flags_byte[FLAG_YSIGN_BIT]}}, poll.data_byte});

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SCREEN_WIDTH) begin
        screen_width <= cfg_data;
      end else if (cfg_index == REG_SCREEN_HEIGHT) begin
        screen_height <= cfg_data;
      end
    end
  end

  // Packet assembly and pointer update
  always_comb begin
    byte_index_next = byte_index;
    flags_byte_next = flags_byte;
    dx_byte_next    = dx_byte;
    position_x_next = position_x;
    position_y_next = position_y;
    buttons_next    = buttons;
    done            = 1'b0;
    if (poll.command) begin
      position_x_next = eff_w[CB:1];
      position_y_next = eff_h[CB:1];
      byte_index_next = IDX_FLAGS;
    end else if (poll.data_ready) begin
      unique case (byte_index)
        IDX_DX: begin
          dx_byte_next    = poll.data_byte;
          byte_index_next = IDX_DY;
        end
        IDX_DY: begin
          byte_index_next = IDX_FLAGS;
          if (!flags_byte[FLAG_XOVF_BIT] && !flags_byte[FLAG_YOVF_BIT]) begin
            position_x_next = clamp_coord(cand_x, eff_w);
            position_y_next = clamp_coord(cand_y, eff_h);
          end
          buttons_next = flags_byte[2:0];
          done         = 1'b1;
        end
        default: begin
          // start of packet: mouse byte with sync bit set
          if (poll.from_aux && poll.data_byte[FLAG_SYNC_BIT]) begin
            flags_byte_next = poll.data_byte;
            byte_index_next = IDX_DX;
          end else begin
            byte_index_next = IDX_FLAGS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= IDX_FLAGS;
      flags_byte <= '0;
      dx_byte    <= '0;
      position_x <= RST_POS_X;
      position_y <= RST_POS_Y;
      buttons    <= '0;
    end else if (poll_acc) begin
      byte_index <= byte_index_next;
      flags_byte <= flags_byte_next;
      dx_byte    <= dx_byte_next;
      position_x <= position_x_next;
      position_y <= position_y_next;
      buttons    <= buttons_next;
    end
  end

  // Report buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (report_acc) begin
        skid_valid <= 1'b0;
      end
    end else begin
      main_valid <= poll_acc || (main_valid && !report.ready);
      skid_valid <= poll_acc && main_valid && !report.ready;
    end
  end

  // Report buffer payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (report_acc) begin
        main_done <= skid_done;
        main_x    <= skid_x;
        main_y    <= skid_y;
        main_btn  <= skid_btn;
      end
    end else if (poll_acc) begin
      if (!main_valid || report.ready) begin
        main_done <= done;
        main_x    <= position_x_next;
        main_y    <= position_y_next;
        main_btn  <= buttons_next;
      end else begin
        skid_done <= done;
        skid_x    <= position_x_next;
        skid_y    <= position_y_next;
        skid_btn  <= buttons_next;
      end
    end
  end

  assign report.valid         = main_valid;
  assign report.packet_done   = main_done;
  assign report.pos_x         = main_x;
  assign report.pos_y         = main_y;
  assign report.button_left   = main_btn[0];
  assign report.button_right  = main_btn[1];
  assign report.button_middle = main_btn[2];

`ifndef SYNTHESIS
  // skid entry only holds a beat behind an occupied output register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid register valid while output register empty");

  // a recenter always restarts packet assembly
  a_recenter_resync: assert property (@(posedge clk) disable iff (rst)
    (poll_acc && poll.command) |=> (byte_index == IDX_FLAGS))
    else $error("recenter did not clear packet index");

  // an empty poll leaves the pointer untouched
  a_idle_poll_still: assert property (@(posedge clk) disable iff (rst)
    (poll_acc && !poll.command && !poll.data_ready)
      |=> ($stable(position_x) && $stable(position_y) && $stable(byte_index)))
    else $error("empty poll changed decoder state");

  // a stalled report with a full skid keeps both entries
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !report.ready) |=> (skid_valid && main_valid))
    else $error("report buffer lost a beat while stalled");
`endif

endmodule

/* verif/ps2_mouse_packet_decoder_test.sv */
// Self-checking testbench for the PS/2 mouse packet decoder: directed and random polls.
module ps2_mouse_packet_decoder_test;
  import ps2m_pkg::*;

  localparam int unsigned COORD_BITS = COORD_BITS_DEFAULT;
  localparam int COORD_SPAN = 1 << COORD_BITS;
  localparam int unsigned ITEMS_PER_PHASE = 115;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT = 4000;
  localparam int unsigned MAX_PRINTED = 40;
  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic       command;
    logic       data_ready;
    logic       from_aux;
    logic [7:0] data_byte;
  } poll_t;

  typedef struct packed {
    logic                  packet_done;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  button_left;
    logic                  button_right;
    logic                  button_middle;
  } pointer_report_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  ps2m_poll_if poll_ch ();
  ps2m_report_if #(.COORD_BITS(COORD_BITS)) rpt_ch ();

  ps2_mouse_packet_decoder #(.COORD_BITS(COORD_BITS)) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .poll     (poll_ch),
    .report   (rpt_ch)
  );

  // Stimulus and expected-report stores
  poll_t           pending_polls[$];
  pointer_report_t expected_reports[$];

  // Shadow of the decoder state
  byte_idx_t                pkt_pos;
  logic [7:0]               hdr_flags;
  logic [7:0]               dx_held;
  logic [COORD_BITS-1:0]    ptr_x;
  logic [COORD_BITS-1:0]    ptr_y;
  logic [2:0]               btn_state;
  logic [CFG_DATA_BITS-1:0] width_reg;
  logic [CFG_DATA_BITS-1:0] height_reg;

  int unsigned error_count;
  int unsigned queued_items;
  int unsigned polls_sent;
  int unsigned polls_seen;
  int unsigned packets_decoded;
  int unsigned recenters_seen;
  int unsigned phases_run;

  // Handshake flags, set at the rising edge and read at the falling edge
  bit poll_taken;
  bit rpt_taken;
  bit poll_calm;
  bit rpt_calm;
  int unsigned poll_gap;
  int unsigned rpt_stall;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Size register as the decoder uses it: 0 acts as 1, large values saturate
  function automatic int usable_size(input logic [CFG_DATA_BITS-1:0] r);
    if (r == 0) return 1;
    if (int'(r) > COORD_SPAN) return COORD_SPAN;
    return int'(r);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_axis(input int v, input int span);
    if (v < 0) v = 0;
    if (v >= span) v = span - 1;
    return v[COORD_BITS-1:0];
  endfunction

  task automatic recenter_ptr();
    ptr_x   = COORD_BITS'(usable_size(width_reg) / 2);
    ptr_y   = COORD_BITS'(usable_size(height_reg) / 2);
    pkt_pos = IDX_FLAGS;
  endtask

  task automatic reset_tracker();
    width_reg  = SCREEN_WIDTH_RESET;
    height_reg = SCREEN_HEIGHT_RESET;
    hdr_flags  = '0;
    dx_held    = '0;
    btn_state  = '0;
    recenter_ptr();
  endtask

  // Advance the shadow state by one poll and form the report it causes
  task automatic decode_poll(input poll_t p, output pointer_report_t r);
    int   dx;
    int   dy;
    logic done;
    done = 1'b0;
    if (p.command) begin
      recenter_ptr();
    end else if (p.data_ready) begin
      case (pkt_pos)
        IDX_DX: begin
          dx_held = p.data_byte;
          pkt_pos = IDX_DY;
        end
        IDX_DY: begin
          pkt_pos = IDX_FLAGS;
          if (!hdr_flags[FLAG_XOVF_BIT] && !hdr_flags[FLAG_YOVF_BIT]) begin
            dx    = int'($signed({hdr_flags[FLAG_XSIGN_BIT], dx_held}));
            dy    = int'($signed({hdr_flags[FLAG_YSIGN_BIT], p.data_byte}));
            ptr_x = clamp_axis(int'(ptr_x) + dx, usable_size(width_reg));
            ptr_y = clamp_axis(int'(ptr_y) - dy, usable_size(height_reg));
          end
          btn_state = hdr_flags[2:0];
          done      = 1'b1;
        end
        default: begin
          // only a mouse byte with the sync bit set opens a packet
          if (p.from_aux && p.data_byte[FLAG_SYNC_BIT]) begin
            hdr_flags = p.data_byte;
            pkt_pos   = IDX_DX;
          end else begin
            pkt_pos = IDX_FLAGS;
          end
        end
      endcase
    end
    r.packet_done   = done;
    r.pos_x         = ptr_x;
    r.pos_y         = ptr_y;
    r.button_left   = btn_state[0];
    r.button_right  = btn_state[1];
    r.button_middle = btn_state[2];
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stimulus builders
  task automatic push_poll(input logic cmd, input logic rdy, input logic aux,
                           input logic [7:0] b);
    poll_t p;
    p.command    = cmd;
    p.data_ready = rdy;
    p.from_aux   = aux;
    p.data_byte  = b;
    pending_polls.push_back(p);
    queued_items++;
  endtask

  function automatic logic [7:0] flag_byte(input logic [2:0] btn, input logic xs,
                                           input logic ys, input logic xo,
                                           input logic yo);
    logic [7:0] f;
    f                 = {5'b0, btn};
    f[FLAG_SYNC_BIT]  = 1'b1;
    f[FLAG_XSIGN_BIT] = xs;
    f[FLAG_YSIGN_BIT] = ys;
    f[FLAG_XOVF_BIT]  = xo;
    f[FLAG_YOVF_BIT]  = yo;
    return f;
  endfunction

  // Well-formed packet; when noisy, empty polls slip in and mid bytes come from any port
  task automatic push_packet(input logic [7:0] flags, input logic [7:0] dx,
                             input logic [7:0] dy, input bit noisy);
    push_poll(1'b0, 1'b1, 1'b1, flags);
    if (noisy && $urandom_range(0, 5) == 0)
      push_poll(1'b0, 1'b0, 1'($urandom_range(0, 1)), 8'($urandom));
    push_poll(1'b0, 1'b1, noisy ? 1'($urandom_range(0, 1)) : 1'b1, dx);
    if (noisy && $urandom_range(0, 5) == 0)
      push_poll(1'b0, 1'b0, 1'($urandom_range(0, 1)), 8'($urandom));
    push_poll(1'b0, 1'b1, noisy ? 1'($urandom_range(0, 1)) : 1'b1, dy);
  endtask

  task automatic add_random_traffic();
    int unsigned r;
    logic [7:0]  f;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      f                = 8'($urandom);
      f[FLAG_SYNC_BIT] = 1'b1;
      if ($urandom_range(0, 7) != 0) begin
        f[FLAG_XOVF_BIT] = 1'b0;
        f[FLAG_YOVF_BIT] = 1'b0;
      end
      push_packet(f, 8'($urandom), 8'($urandom), 1'b1);
    end else if (r < 76) begin
      push_poll(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom));
    end else if (r < 86) begin
      // packet cut short by a recenter
      f                = 8'($urandom);
      f[FLAG_SYNC_BIT] = 1'b1;
      push_poll(1'b0, 1'b1, 1'b1, f);
      if ($urandom_range(0, 1))
        push_poll(1'b0, 1'b1, 1'($urandom_range(0, 1)), 8'($urandom));
      push_poll(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3))
        push_poll(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom));
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for all polls to be taken and every report to come back
  task automatic wait_drained();
    int unsigned waited;
    while (pending_polls.size() != 0 || polls_seen != polls_sent) @(negedge clk);
    waited = 0;
    while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_reports.size() != 0) begin
      flag_error($sformatf("%0d reports never arrived", expected_reports.size()));
      expected_reports.delete();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Poll driver
  always @(negedge clk) begin : poll_driver
    poll_t nxt;
    if (rst) begin
      poll_ch.valid      <= 1'b0;
      poll_ch.command    <= 1'b0;
      poll_ch.data_ready <= 1'b0;
      poll_ch.from_aux   <= 1'b0;
      poll_ch.data_byte  <= '0;
      poll_gap = 0;
    end else if (!poll_ch.valid || poll_taken) begin
      if (poll_gap > 0) begin
        poll_ch.valid <= 1'b0;
        poll_gap--;
      end else if (pending_polls.size() > 0) begin
        nxt = pending_polls.pop_front();
        polls_sent++;
        poll_ch.command    <= nxt.command;
        poll_ch.data_ready <= nxt.data_ready;
        poll_ch.from_aux   <= nxt.from_aux;
        poll_ch.data_byte  <= nxt.data_byte;
        poll_ch.valid      <= 1'b1;
        if ($urandom_range(0, 39) == 0) poll_calm = ($urandom_range(0, 2) == 0);
        poll_gap = pick_gap(poll_calm);
      end else begin
        poll_ch.valid <= 1'b0;
      end
    end
  end

  // Report-side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      rpt_ch.ready <= 1'b0;
      rpt_stall = 0;
    end else if (rpt_stall > 0) begin
      rpt_ch.ready <= 1'b0;
      rpt_stall--;
    end else begin
      rpt_ch.ready <= 1'b1;
      if (rpt_taken) begin
        if ($urandom_range(0, 39) == 0) rpt_calm = ($urandom_range(0, 2) == 0);
        rpt_stall = pick_gap(rpt_calm);
      end
    end
  end

  // Monitor: predict on each poll beat, check each report beat
  always @(posedge clk) begin : monitor
    poll_t           seen_poll;
    pointer_report_t predicted;
    pointer_report_t got;
    pointer_report_t want;
    poll_taken = 1'b0;
    rpt_taken  = 1'b0;
    if (rst) begin
      reset_tracker();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SCREEN_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_SCREEN_HEIGHT) height_reg = cfg_data;
      end
      if (poll_ch.valid && poll_ch.ready) begin
        poll_taken           = 1'b1;
        seen_poll.command    = poll_ch.command;
        seen_poll.data_ready = poll_ch.data_ready;
        seen_poll.from_aux   = poll_ch.from_aux;
        seen_poll.data_byte  = poll_ch.data_byte;
        decode_poll(seen_poll, predicted);
        expected_reports.push_back(predicted);
        polls_seen++;
        if (predicted.packet_done) packets_decoded++;
        if (seen_poll.command) recenters_seen++;
      end
      if (rpt_ch.valid && rpt_ch.ready) begin
        rpt_taken         = 1'b1;
        got.packet_done   = rpt_ch.packet_done;
        got.pos_x         = rpt_ch.pos_x;
        got.pos_y         = rpt_ch.pos_y;
        got.button_left   = rpt_ch.button_left;
        got.button_right  = rpt_ch.button_right;
        got.button_middle = rpt_ch.button_middle;
        if (expected_reports.size() == 0) begin
          flag_error("report beat with no poll outstanding");
        end else begin
          want = expected_reports.pop_front();
          check_field("packet_done", 32'(got.packet_done), 32'(want.packet_done));
          check_field("pos_x", 32'(got.pos_x), 32'(want.pos_x));
          check_field("pos_y", 32'(got.pos_y), 32'(want.pos_y));
          check_field("button_left", 32'(got.button_left), 32'(want.button_left));
          check_field("button_right", 32'(got.button_right), 32'(want.button_right));
          check_field("button_middle", 32'(got.button_middle),
                      32'(want.button_middle));
        end
      end
    end
  end

  // Run limit
  initial begin
    #6000000;
    $display("timeout: decoder stopped making progress");
    $display("[FAIL] regression broken");
    $finish;
  end

  // Sequence: reset, directed polls at reset sizes, then random phases per screen size
  initial begin : sequencer
    logic [CFG_DATA_BITS-1:0] w;
    logic [CFG_DATA_BITS-1:0] h;
    int unsigned              target;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty poll, keyboard byte at start, first byte without sync bit
    push_poll(1'b0, 1'b0, 1'b1, 8'hFF);
    push_poll(1'b0, 1'b1, 1'b0, 8'h0F);
    push_poll(1'b0, 1'b1, 1'b1, 8'hF7);
    // largest positive and most negative deltas
    push_packet(flag_byte(3'b111, 1'b0, 1'b0, 1'b0, 1'b0), 8'hFF, 8'h00, 1'b0);
    push_packet(flag_byte(3'b000, 1'b1, 1'b1, 1'b0, 1'b0), 8'h00, 8'h00, 1'b0);
    // overflow on either axis: buttons only
    push_packet(flag_byte(3'b101, 1'b0, 1'b0, 1'b1, 1'b0), 8'h7F, 8'h7F, 1'b0);
    push_packet(flag_byte(3'b010, 1'b1, 1'b1, 1'b0, 1'b1), 8'h80, 8'h80, 1'b0);
    // keyboard byte and empty poll in the middle of a packet
    push_poll(1'b0, 1'b1, 1'b1, flag_byte(3'b001, 1'b0, 1'b1, 1'b0, 1'b0));
    push_poll(1'b0, 1'b1, 1'b0, 8'h55);
    push_poll(1'b0, 1'b0, 1'b0, 8'hAA);
    push_poll(1'b0, 1'b1, 1'b0, 8'hFF);
    // recenter mid-packet, then a fresh packet
    push_poll(1'b0, 1'b1, 1'b1, flag_byte(3'b110, 1'b1, 1'b0, 1'b0, 1'b0));
    push_poll(1'b1, 1'b1, 1'b1, 8'hFF);
    push_packet(flag_byte(3'b100, 1'b0, 1'b1, 1'b0, 1'b0), 8'h01, 8'hFF, 1'b0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin w = 13'd4096; h = 13'd4096; end
        1: begin w = 13'd1;    h = 13'd1;    end
        2: begin w = 13'd0;    h = 13'd8191; end
        3: begin w = 13'd4097; h = 13'd2;    end
        4: begin w = 13'd3;    h = 13'd0;    end
        5: begin
          w = CFG_DATA_BITS'($urandom_range(2, 600));
          h = CFG_DATA_BITS'($urandom_range(2, 600));
        end
        default: begin
          w = CFG_DATA_BITS'($urandom_range(1, 4096));
          h = CFG_DATA_BITS'($urandom_range(1, 8191));
        end
      endcase
      write_reg(REG_SCREEN_WIDTH, w);
      write_reg(REG_SCREEN_HEIGHT, h);
      if (p == 4) begin
        write_reg(REG_SPARE_A, CFG_DATA_BITS'($urandom));
        write_reg(REG_SPARE_B, CFG_DATA_BITS'($urandom));
      end
      phases_run++;
      // some phases keep the stale position until a moving packet clamps it
      if (p % 2 == 1) push_poll(1'b1, 1'b0, 1'b0, 8'h00);
      target = queued_items + ITEMS_PER_PHASE;
      while (queued_items < target) add_random_traffic();
      wait_drained();
    end

    $display("ran %0d polls across reset size and %0d screen sizes", polls_seen, phases_run);
    $display("%0d packets decoded, %0d recenters, %0d mismatches",
             packets_decoded, recenters_seen, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ps2m_pkg.sv
hw/rtl/ps2m_poll_if.sv
hw/rtl/ps2m_report_if.sv
hw/rtl/ps2_mouse_packet_decoder.sv
verif/ps2_mouse_packet_decoder_test.sv
